@@ rtl/core/fnv1a64_digest_engine_core_macros.svh @@
// ----------------------------------------------------------------------------
// FNV-1a digest engine assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FNV1A64_DIGEST_ENGINE_CORE_MACROS_SVH
`define FNV1A64_DIGEST_ENGINE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FNVDE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FNVDE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/fnvde_pkg.sv @@
// ----------------------------------------------------------------------------
// FNV-1a digest engine package
// Constants, the queue entry type and the FNV-1a fold function.
// ----------------------------------------------------------------------------
package fnvde_pkg;

    localparam logic [63:0] FNV_BASIS        = 64'hCBF2_9CE4_8422_2325;
    localparam int          MAX_DIGEST_BYTES = 64;
    localparam int          CFG_LEN_W        = 7;
    localparam logic [CFG_LEN_W-1:0] CFG_LEN_RESET = 7'd32;
    localparam int          QUEUE_DEPTH      = 4;

    // Register indexes of the configuration port.
    localparam logic REG_DIGEST_LENGTH = 1'b0;

    typedef enum logic [1:0] {
        OP_ABSORB        = 2'd0,
        OP_FINISH        = 2'd1,
        OP_ABSORB_FINISH = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [7:0]  data;
    } fnvde_op_t;

    // One FNV-1a step. The prime is 2^40 + 0x1B3, so the product is a sum of
    // shifted copies of the state, modulo 2^64.
    function automatic logic [63:0] fnv_fold(input logic [63:0] s, input logic [7:0] b);
        logic [63:0] x;
        x = s ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

@@ rtl/core/fnvde_msg_if.sv @@
// ----------------------------------------------------------------------------
// FNV-1a digest engine message channel
// Valid/ready channel that carries one message item.
// ----------------------------------------------------------------------------
interface fnvde_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, output data_byte, output byte_present,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input byte_present,
                    input end_of_message, output ready);
endinterface

@@ rtl/core/fnvde_digest_if.sv @@
// ----------------------------------------------------------------------------
// FNV-1a digest engine digest channel
// Valid/ready channel that carries one digest byte.
// ----------------------------------------------------------------------------
interface fnvde_digest_if;
    logic       valid;
    logic       ready;
    logic [7:0] digest_byte;
    logic       digest_last;

    modport source (output valid, output digest_byte, output digest_last, input ready);
    modport sink   (input valid, input digest_byte, input digest_last, output ready);
endinterface

@@ rtl/core/fnv1a64_digest_engine_core.sv @@
// ----------------------------------------------------------------------------
// FNV-1a 64-bit digest engine
// Hashes a byte stream and emits a configurable-length digest per message.
// ----------------------------------------------------------------------------
// Usage:
//   Message items arrive on the msg channel, one optional byte per item. An
//   item with end_of_message set closes the message after its byte, if any.
//   Digest bytes leave on the digest channel in index order, with
//   digest_last set on the final one. The digest length is set over APB at
//   byte address 0 and must only be written while the engine is idle.
// Absorption and emission:
//   One message byte is absorbed per cycle while no digest is emitted.
//   A closing item folds in the byte count, then L digest bytes follow,
//   L being the clamped digest length; each comes from the single digest
//   state register, as one more FNV-1a step on it. The first digest byte
//   is registered once the back end has popped the closing item.
// Reset and stalls:
//   Reset returns the hash to the offset basis, the byte count to zero and
//   the digest length to 32 bytes, and empties the queue. A stalled receiver
//   holds the output register; the four-entry queue keeps taking items
//   meanwhile and msg.ready drops only when it is full.
// ----------------------------------------------------------------------------
module fnv1a64_digest_engine_core
    import fnvde_pkg::*;
#(
    parameter int MAX_DIGEST_BYTES = fnvde_pkg::MAX_DIGEST_BYTES
)
(
    input  logic           clk,
    input  logic           rst_n,
    fnvde_msg_if.sink      msg,
    fnvde_digest_if.source digest,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    // Digest length as held in the register, before clamping.
    logic [CFG_LEN_W-1:0] digest_length;

    // Queue head toward the back end, and its pop strobe.
    logic      op_valid;
    fnvde_op_t op;
    logic      op_pop;

    fnvde_regs u_regs
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .digest_length (digest_length)
    );

    // The front end drops items that carry neither a byte nor an end mark.
    fnvde_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .msg      (msg),
        .op_valid (op_valid),
        .op       (op),
        .op_pop   (op_pop)
    );

    // The back end stops popping the queue while a digest is being emitted.
    fnvde_back
    #(
        .MAX_DIGEST_BYTES (MAX_DIGEST_BYTES)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .digest_length (digest_length),
        .op_valid      (op_valid),
        .op            (op),
        .op_pop        (op_pop),
        .digest        (digest)
    );

endmodule

@@ rtl/core/fnvde_regs.sv @@
// ----------------------------------------------------------------------------
// FNV-1a digest engine registers
// APB register file holding the digest length.
// ----------------------------------------------------------------------------
module fnvde_regs
    import fnvde_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output logic [CFG_LEN_W-1:0] digest_length
);

    logic [CFG_LEN_W-1:0] len_reg;
    logic [CFG_LEN_W-1:0] len_next;
    logic                 wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_DIGEST_LENGTH);

    always_comb
    begin
        len_next = len_reg;
        if (wr_en)
        begin
            len_next = pwdata[CFG_LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= CFG_LEN_RESET;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_DIGEST_LENGTH: prdata = {{(32-CFG_LEN_W){1'b0}}, len_reg};
            default:           prdata = 32'd0;
        endcase
    end

    assign digest_length = len_reg;

endmodule

@@ rtl/core/fnvde_front.sv @@
// ----------------------------------------------------------------------------
// FNV-1a digest engine front end
// Accepts message items, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module fnvde_front
    import fnvde_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    fnvde_msg_if.sink     msg,
    output logic          op_valid,
    output fnvde_op_t     op,
    input  logic          op_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    fnvde_op_t        queue_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;
    logic             useful;
    fnvde_op_t        new_op;

    // An item with neither a byte nor an end mark changes nothing and is dropped.
    assign useful = msg.byte_present || msg.end_of_message;

    always_comb
    begin
        new_op.data = msg.data_byte;
        if (msg.byte_present && msg.end_of_message)
        begin
            new_op.kind = OP_ABSORB_FINISH;
        end
        else if (msg.end_of_message)
        begin
            new_op.kind = OP_FINISH;
        end
        else
        begin
            new_op.kind = OP_ABSORB;
        end
    end

    assign msg.ready = (count_reg != FULL_CNT);
    assign push      = msg.valid && msg.ready && useful;
    assign op_valid  = (count_reg != '0);
    assign pop       = op_pop && op_valid;
    assign op        = queue_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= new_op;
        end
    end

endmodule

@@ rtl/core/fnvde_back.sv @@
// ----------------------------------------------------------------------------
// FNV-1a digest engine back end
// Absorbs queued bytes into the hash and sequences digest emission.
// ----------------------------------------------------------------------------
module fnvde_back
    import fnvde_pkg::*;
#(
    parameter int MAX_DIGEST_BYTES = fnvde_pkg::MAX_DIGEST_BYTES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [CFG_LEN_W-1:0] digest_length,
    input  logic                 op_valid,
    input  fnvde_op_t            op,
    output logic                 op_pop,
    fnvde_digest_if.source       digest
);

    localparam int IDX_W = $clog2(MAX_DIGEST_BYTES);
    localparam logic [CFG_LEN_W-1:0] MAX_LEN = CFG_LEN_W'(MAX_DIGEST_BYTES);

    typedef enum logic {
        ST_ABSORB = 1'b0,
        ST_EMIT   = 1'b1
    } state_t;

    state_t           state_reg, state_next;
    logic [63:0]      hash_reg, hash_next;
    logic [63:0]      count_reg, count_next;
    logic [63:0]      dig_reg, dig_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] last_idx_reg, last_idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;

    logic [63:0]          absorbed_hash;
    logic [63:0]          absorbed_count;
    logic [63:0]          emit_state;
    logic [CFG_LEN_W-1:0] clamped_len;
    logic                 has_byte;
    logic                 has_end;
    logic                 out_free;

    assign has_byte = op.kind inside {OP_ABSORB, OP_ABSORB_FINISH};
    assign has_end  = op.kind inside {OP_FINISH, OP_ABSORB_FINISH};
    assign out_free = !out_valid_reg || digest.ready;
    assign op_pop   = (state_reg == ST_ABSORB) && op_valid;

    // Zero length is treated as one byte, lengths past the maximum saturate.
    always_comb
    begin
        if (digest_length == '0)
        begin
            clamped_len = CFG_LEN_W'(1);
        end
        else if (digest_length > MAX_LEN)
        begin
            clamped_len = MAX_LEN;
        end
        else
        begin
            clamped_len = digest_length;
        end
    end

    assign absorbed_hash  = has_byte ? fnv_fold(hash_reg, op.data) : hash_reg;
    assign absorbed_count = has_byte ? count_reg + 64'd1 : count_reg;
    assign emit_state     = fnv_fold(dig_reg, {{(8-IDX_W){1'b0}}, idx_reg});

    always_comb
    begin
        state_next     = state_reg;
        hash_next      = hash_reg;
        count_next     = count_reg;
        dig_next       = dig_reg;
        idx_next       = idx_reg;
        last_idx_next  = last_idx_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && digest.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_ABSORB:
            begin
                if (op_valid)
                begin
                    if (has_end)
                    begin
                        dig_next      = absorbed_hash ^ absorbed_count;
                        hash_next     = FNV_BASIS;
                        count_next    = '0;
                        idx_next      = '0;
                        last_idx_next = IDX_W'(clamped_len - 1'b1);
                        state_next    = ST_EMIT;
                    end
                    else
                    begin
                        hash_next  = absorbed_hash;
                        count_next = absorbed_count;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    dig_next       = emit_state;
                    out_byte_next  = emit_state[7:0];
                    out_last_next  = (idx_reg == last_idx_reg);
                    out_valid_next = 1'b1;
                    idx_next       = idx_reg + 1'b1;
                    if (idx_reg == last_idx_reg)
                    begin
                        state_next = ST_ABSORB;
                    end
                end
            end
            default:
            begin
                state_next = ST_ABSORB;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ABSORB;
            hash_reg      <= FNV_BASIS;
            count_reg     <= '0;
            dig_reg       <= '0;
            idx_reg       <= '0;
            last_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            count_reg     <= count_next;
            dig_reg       <= dig_next;
            idx_reg       <= idx_next;
            last_idx_reg  <= last_idx_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign digest.valid       = out_valid_reg;
    assign digest.digest_byte = out_byte_reg;
    assign digest.digest_last = out_last_reg;

endmodule

@@ rtl/core/fnvde_checker.sv @@
// ----------------------------------------------------------------------------
// FNV-1a digest engine checker
// Port-level assertions on the engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "fnv1a64_digest_engine_core_macros.svh"

module fnvde_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        msg_valid,
    input logic        msg_ready,
    input logic        msg_eom,
    input logic        digest_valid,
    input logic        digest_ready,
    input logic [7:0]  digest_byte,
    input logic        digest_last,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);

    // Messages closed on the input that have not yet delivered their last byte.
    logic [3:0] pend_reg;
    logic [3:0] pend_next;
    logic       closed;
    logic       finished;

    assign closed   = msg_valid && msg_ready && msg_eom;
    assign finished = digest_valid && digest_ready && digest_last;

    always_comb
    begin
        pend_next = pend_reg;
        if (closed && !finished)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (finished && !closed)
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `FNVDE_ASSERT_NEXT(a_digest_hold, digest_valid && !digest_ready,
        digest_valid && $stable(digest_byte) && $stable(digest_last),
        "digest item changed while stalled")
    `FNVDE_ASSERT_SAME(a_digest_owned, digest_valid, pend_reg != 4'd0,
        "digest byte without a closed message")
    `FNVDE_ASSERT_NEXT(a_length_readback, psel && penable && pwrite && !paddr[2],
        paddr[2] || (prdata == {25'd0, $past(pwdata[6:0])}),
        "digest length did not read back as written")

endmodule

bind fnv1a64_digest_engine_core fnvde_checker u_fnvde_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .msg_valid    (msg.valid),
    .msg_ready    (msg.ready),
    .msg_eom      (msg.end_of_message),
    .digest_valid (digest.valid),
    .digest_ready (digest.ready),
    .digest_byte  (digest.digest_byte),
    .digest_last  (digest.digest_last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata)
);
